// ===== rtl/gch_pkg.sv =====
// shared types and constants of the grid cell histogram block
// field widths, op and status codes, sequencer states, store command bundle
// no dependencies
package gch_pkg;

	// fixed field widths
	localparam int OP_W     = 2;
	localparam int POS_W    = 11;
	localparam int CELL_W   = 4;
	localparam int SIZE_W   = 11;
	localparam int COUNT_W  = 20;
	localparam int STATUS_W = 3;

	// packed stream widths, rounded up to whole bytes
	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 40;

	// register port
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;
	localparam int REG_IDX_W  = 1;
	localparam int REG_CELL_SIZE = 0;

	// defaults for the top-level parameters
	localparam int BOX_EDGE_DEF       = 1024;
	localparam int MAX_CELLS_DEF      = 16;
	localparam int COUNT_BITS_DEF     = 20;
	localparam int CELL_SIZE_RST      = 64;

	typedef enum logic [OP_W-1:0] {
		OP_ADD   = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK         = 3'd0,
		STAT_NOT_FACTOR = 3'd1,
		STAT_OUT_OF_BOX = 3'd2,
		STAT_SATURATED  = 3'd3,
		STAT_TOO_MANY   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV_X,
		ST_DIV_Y,
		ST_DIV_Z,
		ST_LOOKUP,
		ST_UPDATE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic rd;
		logic wr;
		logic clr;
	} store_cmd_t;

endpackage

// ===== rtl/gch_div.sv =====
// shared restoring divider, one quotient bit per cycle
// used for the cells per axis on a register write and for each coordinate
// depends on gch_pkg
module gch_div import gch_pkg::*; #(
	parameter int DW = 11
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DW-1:0]     dividend,
	input  logic [SIZE_W-1:0] divisor,
	output logic              done,
	output logic [DW-1:0]     quotient,
	output logic [SIZE_W-1:0] remainder
);

	localparam int CNT_W = $clog2(DW + 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DW-1:0]     quo_q;
	logic [SIZE_W-1:0] rem_q;
	logic [SIZE_W-1:0] div_q;
	logic [SIZE_W:0]   trial;
	logic [SIZE_W:0]   diff;
	logic              fits;

	assign trial = {rem_q, quo_q[DW-1]};
	assign diff  = trial - {1'b0, div_q};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], fits};
			rem_q <= fits ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ===== rtl/gch_store.sv =====
// cell counter memory, one port with registered read data
// includes the zeroing sweep run after reset and on a clear op
// depends on gch_pkg
module gch_store import gch_pkg::*; #(
	parameter int AW = 12,
	parameter int CW = 20
) (
	input  logic       clk,
	input  logic       arst_n,
	input  store_cmd_t cmd,
	input  logic [AW-1:0] addr,
	input  logic [CW-1:0] wdata,
	output logic [CW-1:0] rdata,
	output logic       clr_busy
);

	logic [CW-1:0] mem_q [1 << AW];
	logic [CW-1:0] rdata_q;
	logic          clr_busy_q;
	logic [AW-1:0] ptr_q;
	logic          we;
	logic [AW-1:0] wa;
	logic [CW-1:0] wd;

	// sweep owns the write port while it runs
	assign we = clr_busy_q | cmd.wr;
	assign wa = clr_busy_q ? ptr_q : addr;
	assign wd = clr_busy_q ? '0 : wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			ptr_q      <= '0;
		end else if (cmd.clr) begin
			clr_busy_q <= 1'b1;
			ptr_q      <= '0;
		end else if (clr_busy_q) begin
			ptr_q <= ptr_q + AW'(1);
			if (&ptr_q) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wa] <= wd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata    = rdata_q;
	assign clr_busy = clr_busy_q;

endmodule

// ===== rtl/grid_cell_histogram_3d_unit.sv =====
// top level of the 3d grid cell histogram: stream ports, register port, sequencer
// instantiates gch_div (shared divider) and gch_store (counter memory)
// depends on gch_pkg
//
// usage
//   input beats on s_axis: tuser carries the op (add, read, clear), tdata the
//   point coordinates for add and the cell indices for read. every beat gives
//   exactly one result beat on m_axis with count, touched cell and status.
//   cell_size sits at byte address 0 of the apb-style port; a nonzero write
//   reruns the box-over-size division, which holds s_axis_tready low until it
//   ends; a zero write instead marks the size as not a factor of the box
// sequencing (the sequencer takes one item at a time)
//   add: three divisions through the one shared divider, one per axis, then
//   a registered memory read and a write before the emit step loads the result;
//   a rejected add, an out-of-store read and an unused op go straight to emit
//   read: one registered memory read; the next beat can be taken as soon as
//   m_axis_tvalid rises
//   clear: a zeroing sweep of one counter per cycle over 2^(3*IW) counters (4096
//   at the defaults), then the result beat
// reset
//   the same sweep runs after reset; no input beat is taken until it ends,
//   while register writes are taken throughout. cell_size resets to 64
// back pressure
//   the result sits in an output register until m_axis_tready; the next input
//   beat may be taken meanwhile, and the sequencer waits only at the final step
module grid_cell_histogram_3d_unit import gch_pkg::*; #(
	parameter int BOX_EDGE           = BOX_EDGE_DEF,
	parameter int MAX_CELLS_PER_AXIS = MAX_CELLS_DEF,
	parameter int COUNT_BITS         = COUNT_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// input stream
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// pos_x[10:0], pos_y[21:11], pos_z[32:22], cell_x[36:33], cell_y[40:37],
	// cell_z[44:41], zero pad
	input  logic [S_TDATA_W-1:0] s_axis_tdata,
	// op[1:0]
	input  logic [OP_W-1:0]      s_axis_tuser,
	// result stream
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// count[19:0], index_x[23:20], index_y[27:24], index_z[31:28],
	// status[34:32], zero pad
	output logic [M_TDATA_W-1:0] m_axis_tdata,
	// register port
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [PDATA_W-1:0]   pwdata,
	output logic [PDATA_W-1:0]   prdata,
	output logic                 pready
);

	// divider width covers both the box edge and any coordinate
	localparam int BOX_BITS = $clog2(BOX_EDGE + 1);
	localparam int DW = (BOX_BITS > POS_W) ? BOX_BITS : POS_W;
	// per-axis index width and store address width
	localparam int IW = (MAX_CELLS_PER_AXIS > 1) ? $clog2(MAX_CELLS_PER_AXIS) : 1;
	localparam int AW = 3 * IW;
	// reset view of the derived cell geometry
	localparam int CELLS_RST     = BOX_EDGE / CELL_SIZE_RST;
	localparam bit NOT_FACTOR_RST = (BOX_EDGE % CELL_SIZE_RST) != 0;
	localparam bit TOO_MANY_RST   = CELLS_RST > MAX_CELLS_PER_AXIS;

	// ---------------------------------------------------------------- fields
	logic [POS_W-1:0]  in_pos_x;
	logic [POS_W-1:0]  in_pos_y;
	logic [POS_W-1:0]  in_pos_z;
	logic [CELL_W-1:0] in_cell_x;
	logic [CELL_W-1:0] in_cell_y;
	logic [CELL_W-1:0] in_cell_z;
	op_t               in_op;

	assign in_pos_x  = s_axis_tdata[POS_W-1:0];
	assign in_pos_y  = s_axis_tdata[2*POS_W-1:POS_W];
	assign in_pos_z  = s_axis_tdata[3*POS_W-1:2*POS_W];
	assign in_cell_x = s_axis_tdata[3*POS_W+CELL_W-1:3*POS_W];
	assign in_cell_y = s_axis_tdata[3*POS_W+2*CELL_W-1:3*POS_W+CELL_W];
	assign in_cell_z = s_axis_tdata[3*POS_W+3*CELL_W-1:3*POS_W+2*CELL_W];
	assign in_op     = op_t'(s_axis_tuser);

	// ---------------------------------------------------------------- registers
	state_t            state_q;
	state_t            state_d;

	logic [SIZE_W-1:0] cell_size_q;
	logic [DW-1:0]     cells_q;        // cells per axis
	logic              not_factor_q;
	logic              too_many_q;
	logic              cfg_busy_q;     // geometry division in progress

	logic              clr_op_q;       // sweep belongs to a clear op
	logic              is_add_q;
	logic [POS_W-1:0]  pos_y_q;
	logic [POS_W-1:0]  pos_z_q;
	logic [IW-1:0]     ix_q;
	logic [IW-1:0]     iy_q;
	logic [IW-1:0]     iz_q;

	logic [COUNT_W-1:0]  res_count_q;
	logic [CELL_W-1:0]   res_ix_q;
	logic [CELL_W-1:0]   res_iy_q;
	logic [CELL_W-1:0]   res_iz_q;
	status_t             res_status_q;

	logic                 m_valid_q;
	logic [M_TDATA_W-1:0] m_data_q;

	// ---------------------------------------------------------------- config port
	logic cfg_wr;
	logic cfg_sel;

	assign pready  = 1'b1;
	assign cfg_sel = paddr[PADDR_W-1:2] == REG_IDX_W'(REG_CELL_SIZE);
	assign cfg_wr  = psel & penable & pwrite & pready & cfg_sel;
	assign prdata  = cfg_sel ? PDATA_W'(cell_size_q) : '0;

	// ---------------------------------------------------------------- decode
	logic    s_fire;
	logic    out_free;
	logic    add_err;
	status_t add_err_status;
	logic    rd_oob;

	assign s_fire   = s_axis_tvalid & s_axis_tready;
	assign out_free = ~m_valid_q | m_axis_tready;

	// checks in the order the rejections take priority
	always_comb begin
		add_err        = 1'b1;
		add_err_status = STAT_OK;
		if (not_factor_q) begin
			add_err_status = STAT_NOT_FACTOR;
		end else if (too_many_q) begin
			add_err_status = STAT_TOO_MANY;
		end else if (DW'(in_pos_x) > DW'(BOX_EDGE) || DW'(in_pos_y) > DW'(BOX_EDGE) ||
		             DW'(in_pos_z) > DW'(BOX_EDGE)) begin
			add_err_status = STAT_OUT_OF_BOX;
		end else begin
			add_err = 1'b0;
		end
	end

	assign rd_oob = (int'(in_cell_x) >= MAX_CELLS_PER_AXIS) ||
	                (int'(in_cell_y) >= MAX_CELLS_PER_AXIS) ||
	                (int'(in_cell_z) >= MAX_CELLS_PER_AXIS);

	// ---------------------------------------------------------------- divider
	logic              div_item_start;
	logic [DW-1:0]     div_item_dividend;
	logic              div_start;
	logic [DW-1:0]     div_dividend;
	logic [SIZE_W-1:0] div_divisor;
	logic              div_done;
	logic [DW-1:0]     div_quo;
	logic [SIZE_W-1:0] div_rem;
	logic [IW-1:0]     div_idx;
	logic              cfg_nonzero;

	assign cfg_nonzero  = |pwdata[SIZE_W-1:0];
	// the user must issue register writes only with no item in flight (not enforced)
	assign div_start    = (cfg_wr & cfg_nonzero) | div_item_start;
	assign div_dividend = cfg_wr ? DW'(BOX_EDGE) : div_item_dividend;
	assign div_divisor  = cfg_wr ? pwdata[SIZE_W-1:0] : cell_size_q;

	// an index equal to the cell count wraps to the first cell
	assign div_idx = (div_quo == cells_q) ? '0 : div_quo[IW-1:0];

	gch_div #(
		.DW(DW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	// ---------------------------------------------------------------- store
	store_cmd_t           st_cmd;
	logic [AW-1:0]        st_addr;
	logic [COUNT_BITS-1:0] st_rdata;
	logic [COUNT_BITS-1:0] st_wdata;
	logic                 st_clr_busy;
	logic                 st_sat;

	assign st_addr  = {ix_q, iy_q, iz_q};
	assign st_sat   = &st_rdata;
	assign st_wdata = st_rdata + COUNT_BITS'(1);

	gch_store #(
		.AW(AW),
		.CW(COUNT_BITS)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (st_cmd),
		.addr    (st_addr),
		.wdata   (st_wdata),
		.rdata   (st_rdata),
		.clr_busy(st_clr_busy)
	);

	// ---------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (!st_clr_busy) begin
					state_d = clr_op_q ? ST_EMIT : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_fire) begin
					case (in_op)
						OP_ADD:   state_d = add_err ? ST_EMIT : ST_DIV_X;
						OP_READ:  state_d = rd_oob ? ST_EMIT : ST_LOOKUP;
						OP_CLEAR: state_d = ST_CLEAR;
						default:  state_d = ST_EMIT;
					endcase
				end
			end
			ST_DIV_X: begin
				if (div_done) begin
					state_d = ST_DIV_Y;
				end
			end
			ST_DIV_Y: begin
				if (div_done) begin
					state_d = ST_DIV_Z;
				end
			end
			ST_DIV_Z: begin
				if (div_done) begin
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: state_d = ST_UPDATE;
			ST_UPDATE: state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	logic emit_load;

	always_comb begin
		s_axis_tready     = 1'b0;
		div_item_start    = 1'b0;
		div_item_dividend = DW'(in_pos_x);
		st_cmd            = '0;
		emit_load         = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready  = ~cfg_busy_q & ~cfg_wr;
				div_item_start = s_fire & (in_op == OP_ADD) & ~add_err;
				st_cmd.clr     = s_fire & (in_op == OP_CLEAR);
			end
			ST_DIV_X: begin
				div_item_start    = div_done;
				div_item_dividend = DW'(pos_y_q);
			end
			ST_DIV_Y: begin
				div_item_start    = div_done;
				div_item_dividend = DW'(pos_z_q);
			end
			ST_LOOKUP: st_cmd.rd = 1'b1;
			ST_UPDATE: st_cmd.wr = is_add_q & ~st_sat;
			ST_EMIT:   emit_load = out_free;
			default: begin
				s_axis_tready = 1'b0;
			end
		endcase
	end

	// ---------------------------------------------------------------- geometry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_size_q  <= SIZE_W'(CELL_SIZE_RST);
			cells_q      <= DW'(CELLS_RST);
			not_factor_q <= NOT_FACTOR_RST;
			too_many_q   <= TOO_MANY_RST;
			cfg_busy_q   <= 1'b0;
		end else if (cfg_wr) begin
			cell_size_q <= pwdata[SIZE_W-1:0];
			if (!cfg_nonzero) begin
				// zero size never divides the box
				cells_q      <= '0;
				not_factor_q <= 1'b1;
				too_many_q   <= 1'b0;
				cfg_busy_q   <= 1'b0;
			end else begin
				cfg_busy_q <= 1'b1;
			end
		end else if (cfg_busy_q && div_done) begin
			cells_q      <= div_quo;
			not_factor_q <= |div_rem;
			too_many_q   <= div_quo > DW'(MAX_CELLS_PER_AXIS);
			cfg_busy_q   <= 1'b0;
		end
	end

	// ---------------------------------------------------------------- item datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_op_q <= 1'b0;
		end else if (s_fire) begin
			clr_op_q <= in_op == OP_CLEAR;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_fire) begin
					is_add_q    <= in_op == OP_ADD;
					pos_y_q     <= in_pos_y;
					pos_z_q     <= in_pos_z;
					ix_q        <= IW'(in_cell_x);
					iy_q        <= IW'(in_cell_y);
					iz_q        <= IW'(in_cell_z);
					res_count_q <= '0;
					if (in_op == OP_READ && rd_oob) begin
						// out of store: indices echoed, count zero
						res_ix_q     <= in_cell_x;
						res_iy_q     <= in_cell_y;
						res_iz_q     <= in_cell_z;
						res_status_q <= STAT_OUT_OF_BOX;
					end else begin
						res_ix_q     <= '0;
						res_iy_q     <= '0;
						res_iz_q     <= '0;
						res_status_q <= (in_op == OP_ADD) ? add_err_status : STAT_OK;
					end
				end
			end
			ST_DIV_X: begin
				if (div_done) begin
					ix_q <= div_idx;
				end
			end
			ST_DIV_Y: begin
				if (div_done) begin
					iy_q <= div_idx;
				end
			end
			ST_DIV_Z: begin
				if (div_done) begin
					iz_q <= div_idx;
				end
			end
			ST_UPDATE: begin
				res_ix_q <= CELL_W'(ix_q);
				res_iy_q <= CELL_W'(iy_q);
				res_iz_q <= CELL_W'(iz_q);
				if (is_add_q && st_sat) begin
					// counter pinned at its maximum
					res_count_q  <= COUNT_W'(st_rdata);
					res_status_q <= STAT_SATURATED;
				end else begin
					res_count_q  <= is_add_q ? COUNT_W'(st_wdata) : COUNT_W'(st_rdata);
					res_status_q <= STAT_OK;
				end
			end
			default: begin
				is_add_q <= is_add_q;
			end
		endcase
	end

	// ---------------------------------------------------------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (emit_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			m_data_q <= M_TDATA_W'({res_status_q, res_iz_q, res_iy_q, res_ix_q, res_count_q});
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	// ---------------------------------------------------------------- checks
`ifndef SYNTHESIS
	// no beat is taken while the zeroing sweep owns the store
	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !st_clr_busy)
		else $error("input beat accepted during store sweep");

	// a saturating increment never wraps a counter to zero
	a_no_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		st_cmd.wr |-> (st_wdata != '0))
		else $error("counter wrapped on increment");

	// the divider only finishes for a job that somebody is waiting on
	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (cfg_busy_q || state_q == ST_DIV_X || state_q == ST_DIV_Y ||
		              state_q == ST_DIV_Z))
		else $error("divider result with no owner");

	// a result beat only appears from the emit step
	a_emit_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == ST_EMIT))
		else $error("result beat raised outside emit step");
`endif

endmodule
